// ===== sv/rgb_edge_magnitude_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the edge magnitude unit's checker.
// Each expects clk_i and rst_ni in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef RGB_EDGE_MAGNITUDE_UNIT_DEFINES_SVH
`define RGB_EDGE_MAGNITUDE_UNIT_DEFINES_SVH

// same-cycle implication
`define REM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define REM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rem_pkg.sv =====
// ---------------------------------------------------------------------------
// rem_pkg
// Types and constants of the RGB edge magnitude unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rem_pkg;

  localparam int WIDTH_W = 12;   // image_width register
  localparam int ADDR_W  = 3;    // two 32-bit registers
  localparam int DATA_W  = 32;

  localparam logic [WIDTH_W-1:0] WIDTH_RST = 12'd640;
  localparam logic               MODE_RST  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_MODE  = 1'b1;

  // edge_mode codes
  localparam logic MODE_ROBERTS = 1'b0;
  localparam logic MODE_SOBEL   = 1'b1;

  typedef logic [23:0] pix_t;   // blue 23:16, green 15:8, red 7:0

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  edge_res;
    logic [10:0] out_col;
    logic [11:0] out_row;
  } res_t;

  // (|Gx| + |Gy|) / 8 over one channel of a 3x3 window, row-major p0..p8
  function automatic logic [7:0] sobel_mag(
    input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2,
    input logic [7:0] p3, input logic [7:0] p5,
    input logic [7:0] p6, input logic [7:0] p7, input logic [7:0] p8);
    logic [9:0]  t, b, r, l, dy, dx;
    logic [10:0] s;
    t  = {2'b00, p0} + {1'b0, p1, 1'b0} + {2'b00, p2};
    b  = {2'b00, p6} + {1'b0, p7, 1'b0} + {2'b00, p8};
    r  = {2'b00, p2} + {1'b0, p5, 1'b0} + {2'b00, p8};
    l  = {2'b00, p0} + {1'b0, p3, 1'b0} + {2'b00, p6};
    dy = (t > b) ? (t - b) : (b - t);
    dx = (r > l) ? (r - l) : (l - r);
    s  = {1'b0, dy} + {1'b0, dx};
    return s[10:3];
  endfunction

  // (|ul - lr| + |ur - ll|) / 2 over one channel
  function automatic logic [7:0] roberts_mag(
    input logic [7:0] ul, input logic [7:0] ur,
    input logic [7:0] ll, input logic [7:0] lr);
    logic [7:0] d1, d2;
    logic [8:0] s;
    d1 = (ul > lr) ? (ul - lr) : (lr - ul);
    d2 = (ur > ll) ? (ur - ll) : (ll - ur);
    s  = {1'b0, d1} + {1'b0, d2};
    return s[8:1];
  endfunction

endpackage

`default_nettype wire

// ===== sv/rgb_edge_magnitude_unit.sv =====
// ---------------------------------------------------------------------------
// rgb_edge_magnitude_unit
// Streaming Sobel 3x3 / Roberts-cross 2x2 edge strength on raster RGB pixels.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake              word
//  -------   ---------  ---------------------  -----------------------------
//  pixel in  input      in_valid_i/in_ready_o  rem_pkg::pix_in_t
//  edge out  output     out_valid_o/out_ready_i rem_pkg::res_t
//  config    input      APB psel/penable       image_width (0x0), mode (0x4)
//
//  One pixel word per cycle sustained while the output is taken. An accepted
//  word goes to the window stage, where the registered line store read
//  lands, then its result (if any) goes to the output register.
//  Border pixels give no result word.
//  Reset clears the counters and window and loads the config defaults; line stores stay unwritten.
//  A stalled output holds the window stage; input stalls only when both are full.
//
//  Datapath
//  - Both line stores share one memory row {far, near} indexed by column.
//    Read on accept, written when the window stage hands off. A write and
//    a read of the same column at the same edge are covered by a one-entry
//    bypass register.
//  - Window regs 0..2 hold the column left of the current one (top, mid,
//    bottom), 3..5 the column before that.
// ---------------------------------------------------------------------------
`default_nettype none

module rgb_edge_magnitude_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel in
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rem_pkg::pix_in_t             in_word_i,
  // edge out
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rem_pkg::res_t                out_word_o,
  // config
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rem_pkg::ADDR_W-1:0]   paddr,
  input  logic [rem_pkg::DATA_W-1:0]   pwdata,
  output logic [rem_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CMPW = (CW + 1 > rem_pkg::WIDTH_W) ? CW + 1 : rem_pkg::WIDTH_W;

  // ---- config registers ----
  logic [rem_pkg::WIDTH_W-1:0] width_q;
  logic                        mode_q;
  logic                        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= rem_pkg::WIDTH_RST;
      mode_q  <= rem_pkg::MODE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        rem_pkg::REG_WIDTH: width_q <= pwdata[rem_pkg::WIDTH_W-1:0];
        rem_pkg::REG_MODE:  mode_q  <= pwdata[0];
        default:            width_q <= width_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rem_pkg::REG_WIDTH: prdata = rem_pkg::DATA_W'(width_q);
      rem_pkg::REG_MODE:  prdata = rem_pkg::DATA_W'(mode_q);
      default:            prdata = '0;
    endcase
  end

  // ---- handshake ----
  logic s1_valid_q, out_valid_q;
  logic in_fire, s1_adv;

  assign s1_adv      = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = ~s1_valid_q | s1_adv;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  // ---- position counters ----
  logic [CW-1:0]   col_q, col_d, c_new;
  logic [RW-1:0]   row_q, row_d, r_new;
  logic [CMPW-1:0] w_eff, wid_ext;

  // zero acts as one, anything past the line store saturates
  always_comb begin
    wid_ext = CMPW'(width_q);
    if (width_q == '0) begin
      w_eff = CMPW'(1);
    end else if (wid_ext > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = wid_ext;
    end
  end

  always_comb begin
    c_new = in_word_i.frame_start ? '0 : col_q;
    r_new = in_word_i.frame_start ? '0 : row_q;
    if (CMPW'(c_new) + CMPW'(1) >= w_eff) begin
      col_d = '0;
      row_d = (r_new == RW'(MAX_HEIGHT - 1)) ? '0 : r_new + RW'(1);
    end else begin
      col_d = c_new + CW'(1);
      row_d = r_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---- window stage ----
  rem_pkg::pix_t s1_px_q;
  logic [CW-1:0] s1_c_q;
  logic [RW-1:0] s1_r_q;
  logic [47:0]   rdata_q, byp_data_q, row_eff;
  logic          byp_q;
  rem_pkg::pix_t top, mid;
  rem_pkg::pix_t win_q [6];
  rem_pkg::pix_in_t in_w;

  // line store memory: {far, near}
  logic [47:0] lstore_q [MAX_WIDTH];

  assign in_w = in_word_i;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata_q <= lstore_q[c_new];
    end
    if (s1_adv) begin
      lstore_q[s1_c_q] <= {mid, s1_px_q};
    end
  end

  assign row_eff = byp_q ? byp_data_q : rdata_q;
  assign top     = row_eff[47:24];
  assign mid     = row_eff[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        // previous pixel writes the column being read at this very edge
        byp_q      <= s1_adv & (s1_c_q == c_new);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_px_q    <= {in_w.blue, in_w.green, in_w.red};
      s1_c_q     <= c_new;
      s1_r_q     <= r_new;
      byp_data_q <= {mid, s1_px_q};
    end
  end

  // shift the window one column on hand-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top;
      win_q[1] <= mid;
      win_q[2] <= s1_px_q;
    end
  end

  // ---- edge strength, max over R, G, B ----
  logic [7:0]    best, mag;
  logic          emit;
  rem_pkg::res_t res;

  always_comb begin
    best = '0;
    for (int k = 0; k < 3; k++) begin
      if (mode_q == rem_pkg::MODE_SOBEL) begin
        mag = rem_pkg::sobel_mag(
          win_q[3][8*k +: 8], win_q[0][8*k +: 8], top[8*k +: 8],
          win_q[4][8*k +: 8],                     mid[8*k +: 8],
          win_q[5][8*k +: 8], win_q[2][8*k +: 8], s1_px_q[8*k +: 8]);
      end else begin
        mag = rem_pkg::roberts_mag(
          win_q[1][8*k +: 8], mid[8*k +: 8],
          win_q[2][8*k +: 8], s1_px_q[8*k +: 8]);
      end
      if (mag > best) begin
        best = mag;
      end
    end
  end

  // Sobel reports the centre one column left and one row up
  always_comb begin
    res.edge_res = best;
    if (mode_q == rem_pkg::MODE_SOBEL) begin
      emit        = (s1_c_q >= CW'(2)) & (s1_r_q >= RW'(2));
      res.out_col = 11'(s1_c_q - CW'(1));
      res.out_row = 12'(s1_r_q - RW'(1));
    end else begin
      emit        = (s1_c_q != '0) & (s1_r_q != '0);
      res.out_col = 11'(s1_c_q);
      res.out_row = 12'(s1_r_q);
    end
  end

  // ---- output register ----
  rem_pkg::res_t out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_word_q <= res;
    end
  end

  assign out_word_o = out_word_q;

endmodule

`default_nettype wire

// ===== sv/rem_checker.sv =====
// ---------------------------------------------------------------------------
// rem_checker
// Port-level checks on the edge magnitude unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rgb_edge_magnitude_unit_defines.svh"

module rem_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input rem_pkg::res_t out_word_i
);

  // border pixels never produce a word
  `REM_ASSERT(a_no_border, out_valid_i, (out_word_i.out_col != 11'd0) && (out_word_i.out_row != 12'd0), "result on border")

  // an empty output register never blocks the input
  `REM_ASSERT(a_ready_when_drained, !out_valid_i, in_ready_i, "input stalled with output empty")

  // a fresh result follows an accepted pixel
  `REM_ASSERT(a_rise_needs_input, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without pixel")

  // stalled result word holds
  `REM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i), "stalled result changed")

endmodule

bind rgb_edge_magnitude_unit rem_checker u_rem_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_i  (out_word_o)
);

`default_nettype wire
